@@ sv/onewire_master_with_rom_search_top_defines.svh @@
// Assertion macros shared by the 1-Wire master RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ONEWIRE_MASTER_WITH_ROM_SEARCH_TOP_DEFINES_SVH
`define ONEWIRE_MASTER_WITH_ROM_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define OWM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("owm check failed");

// Next-cycle implication, checked out of reset.
`define OWM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("owm check failed");

`endif

@@ sv/owm_pkg.sv @@
// Package for the 1-Wire master: operation codes, register indexes, phases
// and the result struct. No dependencies.
package owm_pkg;

    localparam int CFG_W   = 10;
    localparam int CFG_NUM = 8;
    localparam int ID_W    = 63;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_RESET  = 3'd1;
    localparam logic [2:0] OP_WRITE  = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_SEARCH = 3'd4;

    localparam logic [2:0] CFG_RST_LOW   = 3'd0;
    localparam logic [2:0] CFG_PRES_SMP  = 3'd1;
    localparam logic [2:0] CFG_RST_REC   = 3'd2;
    localparam logic [2:0] CFG_SHORT_LOW = 3'd3;
    localparam logic [2:0] CFG_READ_SMP  = 3'd4;
    localparam logic [2:0] CFG_LONG_LOW  = 3'd5;
    localparam logic [2:0] CFG_SHORT_END = 3'd6;
    localparam logic [2:0] CFG_LONG_END  = 3'd7;

    localparam logic [CFG_W-1:0] RST_LOW_DEF   = 10'd480;
    localparam logic [CFG_W-1:0] PRES_SMP_DEF  = 10'd75;
    localparam logic [CFG_W-1:0] RST_REC_DEF   = 10'd405;
    localparam logic [CFG_W-1:0] SHORT_LOW_DEF = 10'd1;
    localparam logic [CFG_W-1:0] READ_SMP_DEF  = 10'd15;
    localparam logic [CFG_W-1:0] LONG_LOW_DEF  = 10'd60;
    localparam logic [CFG_W-1:0] SHORT_END_DEF = 10'd61;
    localparam logic [CFG_W-1:0] LONG_END_DEF  = 10'd71;

    localparam logic [63:0] SEARCH_ROM_CMD = 64'hF0;

    // search sequencer steps
    localparam logic [2:0] SS_NONE   = 3'd0;
    localparam logic [2:0] SS_CMD    = 3'd1;
    localparam logic [2:0] SS_FIRST  = 3'd2;
    localparam logic [2:0] SS_PAIR_A = 3'd3;
    localparam logic [2:0] SS_PAIR_B = 3'd4;
    localparam logic [2:0] SS_DIR    = 3'd5;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_RST_LOW  = 6'b000010,
        PH_RST_WAIT = 6'b000100,
        PH_RST_REC  = 6'b001000,
        PH_WSLOT    = 6'b010000,
        PH_RSLOT    = 6'b100000
    } phase_t;

    typedef struct packed {
        logic            top_one;
        logic            top_zero;
        logic [ID_W-1:0] id_low;
        logic            read_value;
        logic            presence;
        logic            rejected;
        logic            done;
        logic            busy;
        logic            drive_low;
    } res_t;

endpackage

@@ sv/owm_core.sv @@
// 1-Wire master state and single-item update logic.
// Depends on owm_pkg.
module owm_core #(
    parameter int ROM_BITS   = 64,
    parameter int TIMER_BITS = 10
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_addr,
    input  logic [owm_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                       step_en,
    input  logic [2:0]                 operation,
    input  logic                       line_level,
    input  logic [63:0]                write_data,
    input  logic [6:0]                 write_count,
    output owm_pkg::res_t              res
);

    localparam int IDX_W = $clog2(ROM_BITS);
    localparam logic [16:0] TMAX17 = 17'((1 << TIMER_BITS) - 1);
    localparam logic [TIMER_BITS-1:0] TMAX = TIMER_BITS'((1 << TIMER_BITS) - 1);
    localparam logic [TIMER_BITS-1:0] T_ONE = TIMER_BITS'(1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROM_BITS - 1);

    function automatic logic [TIMER_BITS-1:0] clampt(input logic [owm_pkg::CFG_W-1:0] v);
        logic [16:0] w;
        w = {7'd0, v};
        if (w > TMAX17) w = TMAX17;
        return TIMER_BITS'(w);
    endfunction

    function automatic logic [TIMER_BITS-1:0] atl1(input logic [owm_pkg::CFG_W-1:0] v);
        logic [TIMER_BITS-1:0] c;
        c = clampt(v);
        return (c == '0) ? T_ONE : c;
    endfunction

    logic [owm_pkg::CFG_W-1:0] cfg_reg [owm_pkg::CFG_NUM];

    owm_pkg::phase_t       phase_reg, phase_next;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic [63:0]           tx_reg, tx_next;
    logic [6:0]            bits_reg, bits_next;
    logic                  last_read_reg, last_read_next;
    logic                  pres_reg, pres_next;
    logic [ROM_BITS-1:0]   code_reg, code_next;
    logic [ROM_BITS-1:0]   mask_reg, mask_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      replay_reg, replay_next;
    logic [2:0]            step_reg, step_next;
    logic                  pzero_reg, pzero_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[owm_pkg::CFG_RST_LOW]   <= owm_pkg::RST_LOW_DEF;
            cfg_reg[owm_pkg::CFG_PRES_SMP]  <= owm_pkg::PRES_SMP_DEF;
            cfg_reg[owm_pkg::CFG_RST_REC]   <= owm_pkg::RST_REC_DEF;
            cfg_reg[owm_pkg::CFG_SHORT_LOW] <= owm_pkg::SHORT_LOW_DEF;
            cfg_reg[owm_pkg::CFG_READ_SMP]  <= owm_pkg::READ_SMP_DEF;
            cfg_reg[owm_pkg::CFG_LONG_LOW]  <= owm_pkg::LONG_LOW_DEF;
            cfg_reg[owm_pkg::CFG_SHORT_END] <= owm_pkg::SHORT_END_DEF;
            cfg_reg[owm_pkg::CFG_LONG_END]  <= owm_pkg::LONG_END_DEF;
            phase_reg     <= owm_pkg::PH_IDLE;
            timer_reg     <= '0;
            tx_reg        <= '0;
            bits_reg      <= '0;
            last_read_reg <= 1'b1;
            pres_reg      <= 1'b0;
            code_reg      <= '0;
            mask_reg      <= '0;
            idx_reg       <= '0;
            replay_reg    <= '0;
            step_reg      <= owm_pkg::SS_NONE;
            pzero_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                cfg_reg[cfg_addr] <= cfg_wdata;
            end
            if (step_en) begin
                phase_reg     <= phase_next;
                timer_reg     <= timer_next;
                tx_reg        <= tx_next;
                bits_reg      <= bits_next;
                last_read_reg <= last_read_next;
                pres_reg      <= pres_next;
                code_reg      <= code_next;
                mask_reg      <= mask_next;
                idx_reg       <= idx_next;
                replay_reg    <= replay_next;
                step_reg      <= step_next;
                pzero_reg     <= pzero_next;
            end
        end
    end

    always_comb begin
        logic [TIMER_BITS-1:0] t;
        logic [TIMER_BITS-1:0] slot_end;
        logic [TIMER_BITS-1:0] smp;
        logic                  sub_done;
        logic                  one;
        logic [ROM_BITS-2:0]   diff;
        logic [IDX_W-1:0]      k;
        logic                  done;
        logic                  rej;
        logic [ROM_BITS-2:0]   id_now;
        logic                  top0;
        logic                  top1;

        phase_next     = phase_reg;
        timer_next     = timer_reg;
        tx_next        = tx_reg;
        bits_next      = bits_reg;
        last_read_next = last_read_reg;
        pres_next      = pres_reg;
        code_next      = code_reg;
        mask_next      = mask_reg;
        idx_next       = idx_reg;
        replay_next    = replay_reg;
        step_next      = step_reg;
        pzero_next     = pzero_reg;
        sub_done = 1'b0;
        done     = 1'b0;
        rej      = 1'b0;
        id_now   = '0;
        top0     = 1'b0;
        top1     = 1'b0;
        one      = 1'b0;
        diff     = '0;
        k        = '0;
        smp      = '0;
        slot_end = '0;
        t = (timer_reg >= TMAX) ? TMAX : timer_reg + T_ONE;

        if (operation == owm_pkg::OP_TICK) begin
            unique case (phase_reg)
                owm_pkg::PH_RST_LOW: begin
                    if (t >= atl1(cfg_reg[owm_pkg::CFG_RST_LOW])) begin
                        phase_next = owm_pkg::PH_RST_WAIT;
                        timer_next = '0;
                    end else timer_next = t;
                end
                owm_pkg::PH_RST_WAIT: begin
                    if (t >= atl1(cfg_reg[owm_pkg::CFG_PRES_SMP])) begin
                        pres_next = !line_level;
                        if (clampt(cfg_reg[owm_pkg::CFG_RST_REC]) == '0) sub_done = 1'b1;
                        else begin
                            phase_next = owm_pkg::PH_RST_REC;
                            timer_next = '0;
                        end
                    end else timer_next = t;
                end
                owm_pkg::PH_RST_REC: begin
                    if (t >= clampt(cfg_reg[owm_pkg::CFG_RST_REC])) sub_done = 1'b1;
                    else timer_next = t;
                end
                owm_pkg::PH_WSLOT: begin
                    slot_end = atl1(tx_reg[0] ? cfg_reg[owm_pkg::CFG_SHORT_END]
                                              : cfg_reg[owm_pkg::CFG_LONG_END]);
                    if (t >= slot_end) begin
                        tx_next   = tx_reg >> 1;
                        bits_next = bits_reg - 7'd1;
                        if (bits_next != 7'd0) timer_next = '0;
                        else sub_done = 1'b1;
                    end else timer_next = t;
                end
                owm_pkg::PH_RSLOT: begin
                    slot_end = atl1(cfg_reg[owm_pkg::CFG_SHORT_END]);
                    smp = atl1(cfg_reg[owm_pkg::CFG_READ_SMP]);
                    if (smp > slot_end) smp = slot_end;
                    if (t == smp) last_read_next = line_level;
                    if (t >= slot_end) sub_done = 1'b1;
                    else timer_next = t;
                end
                default: begin
                    phase_next = owm_pkg::PH_IDLE;
                    timer_next = '0;
                end
            endcase
        end else if (operation <= owm_pkg::OP_SEARCH) begin
            if (phase_reg != owm_pkg::PH_IDLE) begin
                rej = 1'b1;
            end else begin
                unique case (operation)
                    owm_pkg::OP_RESET: begin
                        step_next  = owm_pkg::SS_NONE;
                        phase_next = owm_pkg::PH_RST_LOW;
                        timer_next = '0;
                    end
                    owm_pkg::OP_WRITE: begin
                        if (write_count == 7'd0 || write_count > 7'd64) begin
                            done = 1'b1;
                        end else begin
                            tx_next    = write_data;
                            bits_next  = write_count;
                            step_next  = owm_pkg::SS_NONE;
                            phase_next = owm_pkg::PH_WSLOT;
                            timer_next = '0;
                        end
                    end
                    owm_pkg::OP_READ: begin
                        step_next  = owm_pkg::SS_NONE;
                        phase_next = owm_pkg::PH_RSLOT;
                        timer_next = '0;
                    end
                    default: begin
                        code_next   = '0;
                        mask_next   = '0;
                        replay_next = '0;
                        idx_next    = '0;
                        pzero_next  = 1'b0;
                        step_next   = owm_pkg::SS_CMD;
                        phase_next  = owm_pkg::PH_RST_LOW;
                        timer_next  = '0;
                    end
                endcase
            end
        end

        // end of a sub-operation: finish, or advance the search sequencer
        if (sub_done) begin
            timer_next = '0;
            unique case (step_reg)
                owm_pkg::SS_CMD: begin
                    tx_next    = owm_pkg::SEARCH_ROM_CMD;
                    bits_next  = 7'd8;
                    step_next  = owm_pkg::SS_FIRST;
                    phase_next = owm_pkg::PH_WSLOT;
                end
                owm_pkg::SS_FIRST: begin
                    idx_next   = '0;
                    step_next  = owm_pkg::SS_PAIR_A;
                    phase_next = owm_pkg::PH_RSLOT;
                end
                owm_pkg::SS_PAIR_A: begin
                    pzero_next = !last_read_next;
                    step_next  = owm_pkg::SS_PAIR_B;
                    phase_next = owm_pkg::PH_RSLOT;
                end
                owm_pkg::SS_PAIR_B: begin
                    one = !last_read_next;
                    if (idx_reg == LAST_IDX) begin
                        // last pair: report the ID, then backtrack or stop
                        diff   = code_reg[ROM_BITS-2:0] ^ mask_reg[ROM_BITS-2:0];
                        id_now = code_reg[ROM_BITS-2:0];
                        top0   = pzero_reg;
                        top1   = one;
                        for (int j = 0; j < ROM_BITS - 1; j++) begin
                            if (diff[j]) k = IDX_W'(j);
                        end
                        if (diff != '0) begin
                            for (int j = 0; j < ROM_BITS; j++) begin
                                code_next[j] = (IDX_W'(j) < k) ? code_reg[j]
                                                               : (IDX_W'(j) == k);
                                mask_next[j] = (IDX_W'(j) <= k) ? mask_reg[j] : 1'b0;
                            end
                            replay_next = k + IDX_W'(1);
                            step_next   = owm_pkg::SS_CMD;
                            phase_next  = owm_pkg::PH_RST_LOW;
                        end else begin
                            phase_next = owm_pkg::PH_IDLE;
                            step_next  = owm_pkg::SS_NONE;
                            done       = 1'b1;
                        end
                    end else begin
                        if (idx_reg >= replay_reg && one) begin
                            mask_next[idx_reg] = 1'b1;
                            if (!pzero_reg) code_next[idx_reg] = 1'b1;
                        end
                        tx_next    = {63'd0, code_next[idx_reg]};
                        bits_next  = 7'd1;
                        step_next  = owm_pkg::SS_DIR;
                        phase_next = owm_pkg::PH_WSLOT;
                    end
                end
                owm_pkg::SS_DIR: begin
                    idx_next   = idx_reg + IDX_W'(1);
                    step_next  = owm_pkg::SS_PAIR_A;
                    phase_next = owm_pkg::PH_RSLOT;
                end
                default: begin
                    phase_next = owm_pkg::PH_IDLE;
                    step_next  = owm_pkg::SS_NONE;
                    done       = 1'b1;
                end
            endcase
        end

        unique case (phase_next)
            owm_pkg::PH_RST_LOW: res.drive_low = 1'b1;
            owm_pkg::PH_WSLOT:   res.drive_low = timer_next <
                atl1(tx_next[0] ? cfg_reg[owm_pkg::CFG_SHORT_LOW]
                                : cfg_reg[owm_pkg::CFG_LONG_LOW]);
            owm_pkg::PH_RSLOT:   res.drive_low = timer_next <
                atl1(cfg_reg[owm_pkg::CFG_SHORT_LOW]);
            default:             res.drive_low = 1'b0;
        endcase
        res.busy       = phase_next != owm_pkg::PH_IDLE;
        res.done       = done;
        res.rejected   = rej;
        res.presence   = pres_next;
        res.read_value = last_read_next;
        res.id_low     = owm_pkg::ID_W'(id_now);
        res.top_zero   = top0;
        res.top_one    = top1;
    end

endmodule

@@ sv/onewire_master_with_rom_search_top.sv @@
// The result transaction is registered and appears in the cycle after its input is accepted.
// Throughput: one item per cycle; the single output register refills on the
// same edge it drains, so the block stalls only while m_tready is low.
// Reset (aresetn low, synchronous): bus idle, line released, timing
// registers back to defaults, output register empty. No clearing pass.
// Top level of the 1-Wire master with search ROM; depends on owm_pkg, owm_core
// and the shared assertion macro header.
`include "onewire_master_with_rom_search_top_defines.svh"

module onewire_master_with_rom_search_top #(
    parameter int ROM_BITS   = 64,
    parameter int TIMER_BITS = 10
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration: index = position in the timing register list
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_addr,
    input  logic [owm_pkg::CFG_W-1:0] cfg_wdata,
    // input items
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [71:0]               s_tdata,  // line_level, write_data[64], write_count[7]
    input  logic [2:0]                s_tuser,  // operation
    // result items
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [71:0]               m_tdata   // drive_low, busy_res, done_res,
                                                // command_rejected, presence, read_value,
                                                // id_low_bits[63], id_top_zero, id_top_one
);

    owm_pkg::res_t res;
    logic          accept;
    logic          m_valid_reg;
    logic [71:0]   m_data_reg;

    // output register parts the two sides; a draining result frees it at once
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    owm_core #(
        .ROM_BITS   (ROM_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .step_en     (accept),
        .operation   (s_tuser),
        .line_level  (s_tdata[0]),
        .write_data  (s_tdata[64:1]),
        .write_count (s_tdata[71:65]),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // payload register, packed from bit 0 upward
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= {1'b0, res};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // a rejected command never completes anything
    `OWM_ASSERT_NOW(a_rej_no_done, aclk, aresetn, m_tvalid, !(m_tdata[2] && m_tdata[3]))
    // a reported ID comes only with a pass end: restart (busy) or completion
    `OWM_ASSERT_NOW(a_id_at_pass_end, aclk, aresetn,
        m_tvalid && (m_tdata[69] || m_tdata[70] || m_tdata[68:6] != '0),
        m_tdata[1] || m_tdata[2])
    // accepted item always yields a result next cycle
    `OWM_ASSERT_NEXT(a_accept_result, aclk, aresetn, accept, m_tvalid)

endmodule

@@ verif/owm_checker.sv @@
// Checker for the 1-Wire master: snoops the timing register writes and both
// streams, predicts each result transaction and compares it. Needs owm_pkg.
module owm_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [2:0]                  cfg_addr,
    input  logic [owm_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [71:0]                 s_tdata,
    input  logic [2:0]                  s_tuser,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [71:0]                 m_tdata,
    output int                          fails
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [owm_pkg::CFG_W-1:0] TMR_MAX = '1;
    localparam logic [owm_pkg::CFG_W-1:0] TMR_ONE = owm_pkg::CFG_W'(1);
    localparam logic [63:0]               ID_LOW_MASK = 64'h7FFF_FFFF_FFFF_FFFF;

    logic [owm_pkg::CFG_W-1:0] timing [owm_pkg::CFG_NUM];

    owm_pkg::phase_t           bus_phase;
    logic [owm_pkg::CFG_W-1:0] slot_tmr;
    logic [63:0]               tx_bits;
    logic [6:0]                tx_left;
    logic                      read_bit;
    logic                      presence_seen;
    logic [63:0]               rom_code;
    logic [63:0]               ones_seen;
    logic [5:0]                rom_pos;
    logic [6:0]                replay_to;
    logic [2:0]                seq_step;
    logic                      first_zero;

    // per-transaction outputs
    logic                      op_done;
    logic [owm_pkg::ID_W-1:0]  found_low;
    logic                      found_top0;
    logic                      found_top1;

    owm_pkg::res_t             pending_res [$];

    function automatic logic [owm_pkg::CFG_W-1:0] not_zero(
        input logic [owm_pkg::CFG_W-1:0] v);
        return (v == '0) ? TMR_ONE : v;
    endfunction

    task start_phase(input owm_pkg::phase_t p);
        bus_phase = p;
        slot_tmr  = '0;
    endtask

    task end_op();
        bus_phase = owm_pkg::PH_IDLE;
        slot_tmr  = '0;
        seq_step  = owm_pkg::SS_NONE;
        op_done   = 1'b1;
    endtask

    task search_advance();
        logic        one;
        logic [63:0] diff;
        logic [63:0] b;
        int          k;
        case (seq_step)
            owm_pkg::SS_CMD: begin
                tx_bits  = owm_pkg::SEARCH_ROM_CMD;
                tx_left  = 7'd8;
                seq_step = owm_pkg::SS_FIRST;
                start_phase(owm_pkg::PH_WSLOT);
            end
            owm_pkg::SS_FIRST: begin
                rom_pos  = 6'd0;
                seq_step = owm_pkg::SS_PAIR_A;
                start_phase(owm_pkg::PH_RSLOT);
            end
            owm_pkg::SS_PAIR_A: begin
                first_zero = !read_bit;
                seq_step   = owm_pkg::SS_PAIR_B;
                start_phase(owm_pkg::PH_RSLOT);
            end
            owm_pkg::SS_PAIR_B: begin
                one = !read_bit;
                if (rom_pos >= owm_pkg::ID_W) begin
                    diff       = (rom_code ^ ones_seen) & ID_LOW_MASK;
                    found_low  = rom_code[owm_pkg::ID_W-1:0];
                    found_top0 = first_zero;
                    found_top1 = one;
                    if (diff != '0) begin
                        // backtrack to the highest disagreement and take the 1 branch
                        k = owm_pkg::ID_W - 1;
                        while (k > 0 && !diff[k]) k--;
                        rom_code  = (rom_code & ((64'd1 << k) - 64'd1)) | (64'd1 << k);
                        ones_seen = ones_seen & ((64'd2 << k) - 64'd1);
                        replay_to = 7'(k + 1);
                        seq_step  = owm_pkg::SS_CMD;
                        start_phase(owm_pkg::PH_RST_LOW);
                    end else begin
                        end_op();
                    end
                end else begin
                    b = 64'd1 << rom_pos;
                    if ({1'b0, rom_pos} >= replay_to && one) begin
                        ones_seen |= b;
                        if (!first_zero) rom_code |= b;
                    end
                    tx_bits  = {63'd0, rom_code[rom_pos]};
                    tx_left  = 7'd1;
                    seq_step = owm_pkg::SS_DIR;
                    start_phase(owm_pkg::PH_WSLOT);
                end
            end
            owm_pkg::SS_DIR: begin
                rom_pos  = rom_pos + 6'd1;
                seq_step = owm_pkg::SS_PAIR_A;
                start_phase(owm_pkg::PH_RSLOT);
            end
            default: end_op();
        endcase
    endtask

    task phase_over();
        if (seq_step != owm_pkg::SS_NONE) search_advance();
        else end_op();
    endtask

    task advance_tick(input logic lvl);
        logic [owm_pkg::CFG_W-1:0] t;
        logic [owm_pkg::CFG_W-1:0] slot_end;
        logic [owm_pkg::CFG_W-1:0] smp;
        t = (slot_tmr == TMR_MAX) ? TMR_MAX : slot_tmr + TMR_ONE;
        case (bus_phase)
            owm_pkg::PH_RST_LOW: begin
                if (t >= not_zero(timing[owm_pkg::CFG_RST_LOW]))
                    start_phase(owm_pkg::PH_RST_WAIT);
                else slot_tmr = t;
            end
            owm_pkg::PH_RST_WAIT: begin
                if (t >= not_zero(timing[owm_pkg::CFG_PRES_SMP])) begin
                    presence_seen = !lvl;
                    if (timing[owm_pkg::CFG_RST_REC] == '0) phase_over();
                    else start_phase(owm_pkg::PH_RST_REC);
                end else begin
                    slot_tmr = t;
                end
            end
            owm_pkg::PH_RST_REC: begin
                if (t >= timing[owm_pkg::CFG_RST_REC]) phase_over();
                else slot_tmr = t;
            end
            owm_pkg::PH_WSLOT: begin
                slot_end = not_zero(tx_bits[0] ? timing[owm_pkg::CFG_SHORT_END]
                                               : timing[owm_pkg::CFG_LONG_END]);
                if (t >= slot_end) begin
                    tx_bits = tx_bits >> 1;
                    tx_left = tx_left - 7'd1;
                    if (tx_left != 7'd0) slot_tmr = '0;
                    else phase_over();
                end else begin
                    slot_tmr = t;
                end
            end
            owm_pkg::PH_RSLOT: begin
                slot_end = not_zero(timing[owm_pkg::CFG_SHORT_END]);
                smp      = not_zero(timing[owm_pkg::CFG_READ_SMP]);
                if (smp > slot_end) smp = slot_end;
                if (t == smp) read_bit = lvl;
                if (t >= slot_end) phase_over();
                else slot_tmr = t;
            end
            default: begin
                bus_phase = owm_pkg::PH_IDLE;
                slot_tmr  = '0;
            end
        endcase
    endtask

    function automatic logic line_pulled();
        case (bus_phase)
            owm_pkg::PH_RST_LOW: return 1'b1;
            owm_pkg::PH_WSLOT:
                return slot_tmr < not_zero(tx_bits[0] ? timing[owm_pkg::CFG_SHORT_LOW]
                                                      : timing[owm_pkg::CFG_LONG_LOW]);
            owm_pkg::PH_RSLOT:
                return slot_tmr < not_zero(timing[owm_pkg::CFG_SHORT_LOW]);
            default: return 1'b0;
        endcase
    endfunction

    task predict_bus(input logic [2:0] op, input logic lvl, input logic [63:0] wdata,
                     input logic [6:0] wcount, output owm_pkg::res_t r);
        logic rej;
        rej        = 1'b0;
        op_done    = 1'b0;
        found_low  = '0;
        found_top0 = 1'b0;
        found_top1 = 1'b0;
        if (op == owm_pkg::OP_TICK) begin
            if (bus_phase != owm_pkg::PH_IDLE) advance_tick(lvl);
        end else if (op <= owm_pkg::OP_SEARCH) begin
            if (bus_phase != owm_pkg::PH_IDLE) begin
                rej = 1'b1;
            end else begin
                case (op)
                    owm_pkg::OP_RESET: begin
                        seq_step = owm_pkg::SS_NONE;
                        start_phase(owm_pkg::PH_RST_LOW);
                    end
                    owm_pkg::OP_WRITE: begin
                        if (wcount == 7'd0 || wcount > 7'd64) begin
                            op_done = 1'b1;
                        end else begin
                            tx_bits  = wdata;
                            tx_left  = wcount;
                            seq_step = owm_pkg::SS_NONE;
                            start_phase(owm_pkg::PH_WSLOT);
                        end
                    end
                    owm_pkg::OP_READ: begin
                        seq_step = owm_pkg::SS_NONE;
                        start_phase(owm_pkg::PH_RSLOT);
                    end
                    default: begin
                        rom_code   = '0;
                        ones_seen  = '0;
                        replay_to  = '0;
                        rom_pos    = '0;
                        first_zero = 1'b0;
                        seq_step   = owm_pkg::SS_CMD;
                        start_phase(owm_pkg::PH_RST_LOW);
                    end
                endcase
            end
        end
        r.drive_low  = line_pulled();
        r.busy       = bus_phase != owm_pkg::PH_IDLE;
        r.done       = op_done;
        r.rejected   = rej;
        r.presence   = presence_seen;
        r.read_value = read_bit;
        r.id_low     = found_low;
        r.top_zero   = found_top0;
        r.top_one    = found_top1;
    endtask

    task report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        fails++;
    endtask

    always @(posedge aclk) begin
        owm_pkg::res_t want;
        owm_pkg::res_t got;
        if (!aresetn) begin
            timing[owm_pkg::CFG_RST_LOW]   = owm_pkg::RST_LOW_DEF;
            timing[owm_pkg::CFG_PRES_SMP]  = owm_pkg::PRES_SMP_DEF;
            timing[owm_pkg::CFG_RST_REC]   = owm_pkg::RST_REC_DEF;
            timing[owm_pkg::CFG_SHORT_LOW] = owm_pkg::SHORT_LOW_DEF;
            timing[owm_pkg::CFG_READ_SMP]  = owm_pkg::READ_SMP_DEF;
            timing[owm_pkg::CFG_LONG_LOW]  = owm_pkg::LONG_LOW_DEF;
            timing[owm_pkg::CFG_SHORT_END] = owm_pkg::SHORT_END_DEF;
            timing[owm_pkg::CFG_LONG_END]  = owm_pkg::LONG_END_DEF;
            bus_phase     = owm_pkg::PH_IDLE;
            slot_tmr      = '0;
            tx_bits       = '0;
            tx_left       = '0;
            read_bit      = 1'b1;
            presence_seen = 1'b0;
            rom_code      = '0;
            ones_seen     = '0;
            rom_pos       = '0;
            replay_to     = '0;
            seq_step      = owm_pkg::SS_NONE;
            first_zero    = 1'b0;
            fails         = 0;
            pending_res.delete();
        end else begin
            // a transaction on this edge still sees the old timing
            if (s_tvalid && s_tready) begin
                predict_bus(s_tuser, s_tdata[0], s_tdata[64:1], s_tdata[71:65], want);
                pending_res = {pending_res, want};
            end
            if (cfg_we) timing[cfg_addr] = cfg_wdata;
            if (m_tvalid && m_tready) begin
                got = owm_pkg::res_t'(m_tdata[$bits(owm_pkg::res_t)-1:0]);
                if (pending_res.size() == 0) begin
                    report("unexpected transaction", m_tdata[63:0], 64'd0);
                end else begin
                    want = pending_res.pop_front();
                    if (got.drive_low != want.drive_low)
                        report("drive_low", 64'(got.drive_low), 64'(want.drive_low));
                    if (got.busy != want.busy)
                        report("busy", 64'(got.busy), 64'(want.busy));
                    if (got.done != want.done)
                        report("done", 64'(got.done), 64'(want.done));
                    if (got.rejected != want.rejected)
                        report("rejected", 64'(got.rejected), 64'(want.rejected));
                    if (got.presence != want.presence)
                        report("presence", 64'(got.presence), 64'(want.presence));
                    if (got.read_value != want.read_value)
                        report("read_value", 64'(got.read_value), 64'(want.read_value));
                    if (got.id_low != want.id_low)
                        report("id_low", 64'(got.id_low), 64'(want.id_low));
                    if (got.top_zero != want.top_zero)
                        report("top_zero", 64'(got.top_zero), 64'(want.top_zero));
                    if (got.top_one != want.top_one)
                        report("top_one", 64'(got.top_one), 64'(want.top_one));
                end
            end
        end
    end

endmodule

@@ verif/tb_top.sv @@
// Testbench top for the 1-Wire master with search ROM: clock, reset, stimulus
// and verdict. Depends on owm_pkg, the RTL top and owm_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // generous bound for some 700 transactions with idling
    localparam int CYCLE_LIMIT = 50_000;

    logic                        aclk      = 1'b0;
    logic                        aresetn   = 1'b0;
    logic                        cfg_we    = 1'b0;
    logic [2:0]                  cfg_addr  = '0;
    logic [owm_pkg::CFG_W-1:0]   cfg_wdata = '0;
    logic                        s_tvalid  = 1'b0;
    logic                        s_tready;
    logic [71:0]                 s_tdata   = '0;   // line_level, write_data[64], write_count[7]
    logic [2:0]                  s_tuser   = '0;   // operation
    logic                        m_tvalid;
    logic                        m_tready  = 1'b0;
    logic [71:0]                 m_tdata;          // drive_low, busy, done, rejected, presence,
                                                   // read_value, id_low[63], top_zero, top_one
    int                          fails;

    int   sent       = 0;   // input transactions accepted
    int   rcvd       = 0;   // result transactions accepted
    logic last_busy  = 1'b0;
    bit   quiet      = 1'b0; // no idling on either side
    int   stall_left = 0;
    int   cycles     = 0;

    onewire_master_with_rom_search_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    owm_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fails(fails)
    );

    always #10 aclk = ~aclk;

    // receiver back-pressure in random bursts
    always @(posedge aclk) begin
        if (quiet || !aresetn) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 6) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // track results so the stimulus can tell when the bus has gone idle
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            rcvd      <= rcvd + 1;
            last_busy <= m_tdata[1];
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // one input transaction, with an optional idle burst in front
    task automatic send(input logic [2:0] op, input logic lvl,
                        input logic [63:0] wdata, input logic [6:0] wcount);
        int gap;
        gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {wcount, wdata, lvl};
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic tick(input logic lvl);
        send(owm_pkg::OP_TICK, lvl, {$urandom, $urandom}, 7'($urandom));
    endtask

    // hold off until every result is back, then tick the bus (line high)
    // until the block reports idle
    task automatic settle();
        forever begin
            s_tvalid <= 1'b0;
            while (sent != rcvd) @(posedge aclk);
            if (!last_busy) break;
            repeat (16) tick(1'b1);
        end
        repeat (2) @(posedge aclk);
    endtask

    task automatic set_timing(input int rst_low, input int pres, input int rec,
                              input int short_low, input int rd_smp, input int long_low,
                              input int short_end, input int long_end);
        logic [2:0]                idx [owm_pkg::CFG_NUM];
        logic [owm_pkg::CFG_W-1:0] val [owm_pkg::CFG_NUM];
        idx = '{owm_pkg::CFG_RST_LOW, owm_pkg::CFG_PRES_SMP, owm_pkg::CFG_RST_REC,
                owm_pkg::CFG_SHORT_LOW, owm_pkg::CFG_READ_SMP, owm_pkg::CFG_LONG_LOW,
                owm_pkg::CFG_SHORT_END, owm_pkg::CFG_LONG_END};
        val = '{owm_pkg::CFG_W'(rst_low), owm_pkg::CFG_W'(pres), owm_pkg::CFG_W'(rec),
                owm_pkg::CFG_W'(short_low), owm_pkg::CFG_W'(rd_smp),
                owm_pkg::CFG_W'(long_low), owm_pkg::CFG_W'(short_end),
                owm_pkg::CFG_W'(long_end)};
        s_tvalid <= 1'b0;
        for (int i = 0; i < owm_pkg::CFG_NUM; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= idx[i];
            cfg_wdata <= val[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_timing();
        set_timing($urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 3),
                   $urandom_range(0, 3), $urandom_range(0, 4), $urandom_range(0, 3),
                   $urandom_range(0, 4), $urandom_range(0, 4));
    endtask

    // random mix of ticks and short commands; commands hit a busy bus often
    task automatic random_items(input int n);
        int         pick;
        logic       lvl;
        logic [6:0] cnt;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            lvl  = 1'($urandom_range(0, 1));
            cnt  = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(65, 127))
                                               : 7'($urandom_range(1, 8));
            if (pick < 70)      tick(lvl);
            else if (pick < 78) send(owm_pkg::OP_RESET, lvl, {$urandom, $urandom}, cnt);
            else if (pick < 88) send(owm_pkg::OP_WRITE, lvl, {$urandom, $urandom}, cnt);
            else if (pick < 96) send(owm_pkg::OP_READ, lvl, {$urandom, $urandom}, cnt);
            else send(3'($urandom_range(5, 7)), lvl, {$urandom, $urandom}, cnt);
        end
    endtask

    // one search under one-tick slots: pair j is read on ticks 11+3j and
    // 12+3j after the command. One chosen pair answers 0/0 (a branch point),
    // the others 1/1, 0/1 or 1/0, so the search ends after its second pass.
    task automatic search_run();
        int   branch;
        int   kind;
        int   pos;
        logic lvl;
        branch = $urandom_range(4, 58);
        kind   = 0;
        send(owm_pkg::OP_SEARCH, 1'b1, '0, 7'd1);
        for (int i = 1; i <= 200; i++) begin
            lvl = 1'b1;
            if (i == 2) begin
                lvl = 1'b0;                      // presence on the sample tick
            end else if (i >= 11) begin
                pos = (i - 11) % 3;
                if (pos == 0) kind = ((i - 11) / 3 == branch) ? 3 : $urandom_range(0, 2);
                if (kind == 3 && pos != 2) lvl = 1'b0;
                else if (kind == 1 && pos == 0) lvl = 1'b0;
                else if (kind == 2 && pos == 1) lvl = 1'b0;
            end
            tick(lvl);
        end
        settle();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, power-on timing
        tick(1'b0);                              // tick on an idle bus
        send(3'd5, 1'b0, '1, 7'd64);             // undefined operations
        send(3'd6, 1'b1, '0, 7'd1);
        send(3'd7, 1'b0, '1, 7'd127);
        send(owm_pkg::OP_WRITE, 1'b0, '1, 7'd0); // bad counts finish at once
        send(owm_pkg::OP_WRITE, 1'b0, '1, 7'd65);
        send(owm_pkg::OP_WRITE, 1'b0, '1, 7'd127);
        send(owm_pkg::OP_READ, 1'b0, '0, 7'd1);
        send(owm_pkg::OP_RESET, 1'b0, '0, 7'd1); // busy: rejected
        send(owm_pkg::OP_WRITE, 1'b0, '1, 7'd4);
        send(owm_pkg::OP_SEARCH, 1'b0, '0, 7'd1);
        send(owm_pkg::OP_READ, 1'b0, '0, 7'd1);
        repeat (64) tick(1'b0);                  // read sees a low line
        settle();

        // short timing: reset with presence, a byte write, a read
        set_timing(3, 2, 2, 1, 2, 2, 3, 4);
        send(owm_pkg::OP_RESET, 1'b1, '0, 7'd1);
        repeat (6) tick(1'b0);                   // presence seen
        settle();
        send(owm_pkg::OP_WRITE, 1'b0, {$urandom, $urandom}, 7'd8);
        settle();
        send(owm_pkg::OP_READ, 1'b0, '0, 7'd1);
        repeat (3) tick(1'b0);
        settle();

        // all zero: minimum lengths, reset ends on the presence sample
        set_timing(0, 0, 0, 0, 0, 0, 0, 0);
        send(owm_pkg::OP_RESET, 1'b0, '0, 7'd1);
        repeat (3) tick(1'b0);
        settle();
        send(owm_pkg::OP_WRITE, 1'b0, 64'h5, 7'd3);
        settle();
        search_run();

        // read sample placed after the slot end
        set_timing(2, 1, 1, 1, 5, 2, 2, 3);
        send(owm_pkg::OP_READ, 1'b0, '0, 7'd1);
        tick(1'b0);
        tick(1'b0);
        settle();

        // random phase with short timing
        random_timing();
        random_items(50);
        settle();

        // closing stretch without idling
        quiet = 1'b1;
        random_timing();
        random_items(40);
        settle();

        s_tvalid <= 1'b0;
        while (sent != rcvd) @(posedge aclk);
        repeat (5) @(posedge aclk);
        if (fails == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/owm_pkg.sv
sv/owm_core.sv
sv/onewire_master_with_rom_search_top.sv
verif/owm_checker.sv
verif/tb_top.sv
